// File: rtl/variance_excursion_monitor_defines.svh
// ----------------------------------------------------------------------------
// Variance excursion monitor assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VARIANCE_EXCURSION_MONITOR_DEFINES_SVH
`define VARIANCE_EXCURSION_MONITOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// prop must hold at every clock edge
`define VEM_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(prop)) else $error("variance_excursion_monitor: check failed");
// cons must hold in the cycle after ante
`define VEM_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |=> (cons)) else \
	$error("variance_excursion_monitor: check failed");
`else
`define VEM_ASSERT(lbl, prop)
`define VEM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/vem_pkg.sv
// ----------------------------------------------------------------------------
// vem_pkg
// Shared types and constants of the variance excursion monitor.
// ----------------------------------------------------------------------------
package vem_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int DATA_W = 32;
	localparam int CH_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int FIFO_DEPTH = 4;

	localparam logic [DATA_W-1:0] WARN_RESET = 32'h0000_8000;
	localparam logic [DATA_W-1:0] FAIL_RESET = 32'h0001_0000;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_EOL = 1'b1;

	localparam logic CFG_SEL_WARN = 1'b0;
	localparam logic CFG_SEL_FAIL = 1'b1;

	localparam logic SEV_WARN = 1'b0;
	localparam logic SEV_FAIL = 1'b1;
	localparam logic [3:0] SCORE_WARN = 4'd4;
	localparam logic [3:0] SCORE_FAIL = 4'd10;

	// one closed event, front to back
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic [DATA_W-1:0] start;
		logic [DATA_W-1:0] stop;
		logic [DATA_W-1:0] peak;
		logic last;
	} close_rec_t;

	typedef struct packed {
		logic scan_busy;
		logic any_open;
	} front_stat_t;

endpackage

// File: rtl/vem_fifo.sv
// ----------------------------------------------------------------------------
// vem_fifo
// Short queue of closed-event records between the front and back parts.
// ----------------------------------------------------------------------------
module vem_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vem_pkg::close_rec_t wr_rec,
	output logic                full,
	input  logic                pop,
	output vem_pkg::close_rec_t rd_rec,
	output logic                not_empty
);

	localparam int PW = $clog2(vem_pkg::FIFO_DEPTH);
	localparam int CW = PW + 1;

	vem_pkg::close_rec_t entry_q [vem_pkg::FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(vem_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign rd_rec = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(vem_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PW'(vem_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= wr_rec;
	end

endmodule

// File: rtl/vem_front.sv
// ----------------------------------------------------------------------------
// vem_front
// Accepts items, keeps per-channel event state and queues closed events.
// ----------------------------------------------------------------------------
module vem_front #(
	parameter int NUM_CHANNELS = vem_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic                                     kind,
	input  logic [vem_pkg::CH_W-1:0]                 channel,
	input  logic [vem_pkg::DATA_W-1:0]               sample_value,
	input  logic [vem_pkg::DATA_W-1:0]               time_stamp,
	input  logic [NUM_CHANNELS-1:0][vem_pkg::DATA_W-1:0] warn_level,
	output logic                                     push,
	output vem_pkg::close_rec_t                      push_rec,
	input  logic                                     full,
	output vem_pkg::front_stat_t                     stat
);

	localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [NUM_CHANNELS-1:0] open_q;
	logic [NUM_CHANNELS-1:0] scan_mask_q;
	logic [vem_pkg::DATA_W-1:0] scan_time_q;
	logic [vem_pkg::DATA_W-1:0] peak_q [NUM_CHANNELS];
	logic [vem_pkg::DATA_W-1:0] otime_q [NUM_CHANNELS];

	logic scan_busy;
	logic accept;
	logic ch_ok;
	logic [IW-1:0] pick;
	logic [NUM_CHANNELS-1:0] pick_bit;
	logic [IW-1:0] idx;
	logic cur_open;
	logic [vem_pkg::DATA_W-1:0] cur_peak;
	logic [vem_pkg::DATA_W-1:0] cur_warn;
	logic above_peak;
	logic above_warn;
	logic is_sample;
	logic is_eol;
	logic do_open;
	logic do_raise;
	logic do_close;
	logic scan_push;

	assign scan_busy = |scan_mask_q;
	assign in_ready = !scan_busy && !full;
	assign accept = in_valid && in_ready;
	assign ch_ok = (32'(channel) < NUM_CHANNELS);

	// lowest pending channel goes first
	always_comb begin
		pick = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (scan_mask_q[i]) pick = IW'(i);
		end
	end

	assign pick_bit = NUM_CHANNELS'(1) << pick;
	assign idx = scan_busy ? pick : channel[IW-1:0];

	assign cur_open = open_q[idx];
	assign cur_peak = peak_q[idx];
	assign cur_warn = warn_level[idx];
	assign above_peak = sample_value > cur_peak;
	assign above_warn = sample_value > cur_warn;

	assign is_sample = accept && (kind == vem_pkg::KIND_SAMPLE) && ch_ok;
	assign is_eol = accept && (kind == vem_pkg::KIND_EOL);
	assign do_open = is_sample && !cur_open && above_warn;
	assign do_raise = is_sample && cur_open && above_peak;
	assign do_close = is_sample && cur_open && !above_peak && !above_warn;
	assign scan_push = scan_busy && !full;

	assign push = do_close || scan_push;
	assign push_rec.ch = scan_busy ? vem_pkg::CH_W'(pick) : channel;
	assign push_rec.start = otime_q[idx];
	assign push_rec.stop = scan_busy ? scan_time_q : time_stamp;
	assign push_rec.peak = cur_peak;
	assign push_rec.last = scan_busy ? ((scan_mask_q & ~pick_bit) == '0) : 1'b1;

	assign stat.scan_busy = scan_busy;
	assign stat.any_open = |open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			scan_mask_q <= '0;
		end else begin
			if (is_eol) begin
				// snapshot open events for the drain, close them all
				scan_mask_q <= open_q;
				open_q <= '0;
			end else if (scan_push) begin
				scan_mask_q <= scan_mask_q & ~pick_bit;
			end else if (do_open) begin
				open_q[idx] <= 1'b1;
			end else if (do_close) begin
				open_q[idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_eol) scan_time_q <= time_stamp;
		if (do_open || do_raise) peak_q[idx] <= sample_value;
		if (do_open) otime_q[idx] <= time_stamp;
	end

endmodule

// File: rtl/vem_back.sv
// ----------------------------------------------------------------------------
// vem_back
// Grades queued events against the fail level and holds the result register.
// ----------------------------------------------------------------------------
module vem_back #(
	parameter int NUM_CHANNELS = vem_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     fifo_valid,
	input  vem_pkg::close_rec_t                      fifo_rec,
	output logic                                     pop,
	input  logic [NUM_CHANNELS-1:0][vem_pkg::DATA_W-1:0] fail_level,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [vem_pkg::CH_W-1:0]                 event_channel,
	output logic [vem_pkg::DATA_W-1:0]               start_time,
	output logic [vem_pkg::DATA_W-1:0]               stop_time,
	output logic [vem_pkg::DATA_W-1:0]               peak_value,
	output logic                                     severity,
	output logic [3:0]                               score,
	output logic                                     last
);

	localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic out_valid_q;
	logic is_fail;

	assign pop = fifo_valid && (!out_valid_q || out_ready);
	assign is_fail = fifo_rec.peak > fail_level[fifo_rec.ch[IW-1:0]];
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (pop) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			event_channel <= fifo_rec.ch;
			start_time <= fifo_rec.start;
			stop_time <= fifo_rec.stop;
			peak_value <= fifo_rec.peak;
			severity <= is_fail ? vem_pkg::SEV_FAIL : vem_pkg::SEV_WARN;
			score <= is_fail ? vem_pkg::SCORE_FAIL : vem_pkg::SCORE_WARN;
			last <= fifo_rec.last;
		end
	end

endmodule

// File: rtl/variance_excursion_monitor.sv
// Samples: one transaction per cycle while in_ready is high.
// End of log: holds input while open events drain, one per cycle if the queue has room.
// A closed event passes the front update, the 4-deep event queue and the output register.
// Reset: open flags and queue clear, thresholds return to defaults;
// peak and start-time storage is not cleared.
// ----------------------------------------------------------------------------
// variance_excursion_monitor
// Per-channel excursion tracking with threshold registers and result output.
// ----------------------------------------------------------------------------
`include "variance_excursion_monitor_defines.svh"

module variance_excursion_monitor #(
	parameter int NUM_CHANNELS = vem_pkg::NUM_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [vem_pkg::CH_W-1:0]          channel,
	input  logic [vem_pkg::DATA_W-1:0]        sample_value,
	input  logic [vem_pkg::DATA_W-1:0]        time_stamp,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [vem_pkg::CH_W-1:0]          event_channel,
	output logic [vem_pkg::DATA_W-1:0]        start_time,
	output logic [vem_pkg::DATA_W-1:0]        stop_time,
	output logic [vem_pkg::DATA_W-1:0]        peak_value,
	output logic                              severity,
	output logic [3:0]                        score,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vem_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vem_pkg::DATA_W-1:0]        cfg_data
);

	localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [NUM_CHANNELS-1:0][vem_pkg::DATA_W-1:0] warn_q;
	logic [NUM_CHANNELS-1:0][vem_pkg::DATA_W-1:0] fail_q;
	logic [vem_pkg::CFG_IDX_W-2:0] cfg_ch;
	logic cfg_hit;

	logic push;
	logic full;
	logic pop;
	logic fifo_valid;
	vem_pkg::close_rec_t push_rec;
	vem_pkg::close_rec_t fifo_rec;
	vem_pkg::front_stat_t fstat;

	assign cfg_ready = 1'b1;
	assign cfg_ch = cfg_index[vem_pkg::CFG_IDX_W-1:1];
	// drop writes to channels that are not built
	assign cfg_hit = cfg_valid && (32'(cfg_ch) < NUM_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				warn_q[i] <= vem_pkg::WARN_RESET;
				fail_q[i] <= vem_pkg::FAIL_RESET;
			end
		end else if (cfg_hit) begin
			if (cfg_index[0] == vem_pkg::CFG_SEL_WARN) warn_q[cfg_ch[IW-1:0]] <= cfg_data;
			else fail_q[cfg_ch[IW-1:0]] <= cfg_data;
		end
	end

	vem_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.channel     (channel),
		.sample_value(sample_value),
		.time_stamp  (time_stamp),
		.warn_level  (warn_q),
		.push        (push),
		.push_rec    (push_rec),
		.full        (full),
		.stat        (fstat)
	);

	vem_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_rec   (push_rec),
		.full     (full),
		.pop      (pop),
		.rd_rec   (fifo_rec),
		.not_empty(fifo_valid)
	);

	vem_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_valid   (fifo_valid),
		.fifo_rec     (fifo_rec),
		.pop          (pop),
		.fail_level   (fail_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_channel(event_channel),
		.start_time   (start_time),
		.stop_time    (stop_time),
		.peak_value   (peak_value),
		.severity     (severity),
		.score        (score),
		.last         (last)
	);

	`VEM_ASSERT(a_no_queue_overflow, !(push && full))
	`VEM_ASSERT(a_no_accept_in_drain, !(in_valid && in_ready && fstat.scan_busy))
	`VEM_ASSERT_NEXT(a_eol_closes_all, in_valid && in_ready && (kind == vem_pkg::KIND_EOL), !fstat.any_open)

endmodule
